FILE: src/bes_pkg.sv
// ----------------------------------------------------------------------------
// bes_pkg
// Shared field widths, function codes and status codes of the bipartite
// edge swap sampler.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int IDX_W = 8;
  localparam int LBL_W = 6;
  localparam int CNT_W = 9;
  localparam int FN_W  = 2;
  localparam int ST_W  = 3;

  typedef logic [FN_W-1:0] func_t;
  typedef logic [ST_W-1:0] status_t;

  localparam func_t FN_LOAD  = 2'd0;
  localparam func_t FN_SWAP  = 2'd1;
  localparam func_t FN_CLEAR = 2'd2;
  localparam func_t FN_READ  = 2'd3;

  localparam status_t ST_SWAPPED  = 3'd0;
  localparam status_t ST_REJECTED = 3'd1;
  localparam status_t ST_SAME     = 3'd2;
  localparam status_t ST_BAD      = 3'd3;
  localparam status_t ST_DONE     = 3'd4;
  localparam status_t ST_READ     = 3'd5;

endpackage

FILE: src/bes_ram.sv
// ----------------------------------------------------------------------------
// bes_ram
// Generic single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module bes_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[addr];
    if (we) begin
      mem_r[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bes_row_upd.sv
// ----------------------------------------------------------------------------
// bes_row_upd
// Swap decision and adjacency row update: tests the two new pairs and forms
// the rewritten rows of both nodes.
// ----------------------------------------------------------------------------
module bes_row_upd #(
  parameter int GRP_BITS = 64
) (
  input  logic [GRP_BITS-1:0]       row_a,
  input  logic [GRP_BITS-1:0]       row_b,
  input  logic [bes_pkg::LBL_W-1:0] node_a,
  input  logic [bes_pkg::LBL_W-1:0] node_b,
  input  logic [bes_pkg::LBL_W-1:0] grp_a,
  input  logic [bes_pkg::LBL_W-1:0] grp_b,
  output logic                      hit,
  output logic [GRP_BITS-1:0]       new_a,
  output logic [GRP_BITS-1:0]       new_b
);
  import bes_pkg::*;

  logic [GRP_BITS-1:0] m_a;
  logic [GRP_BITS-1:0] m_b;
  logic [GRP_BITS-1:0] xm_a;
  logic [GRP_BITS-1:0] xm_b;
  logic                same_node;

  always_comb begin
    for (int j = 0; j < GRP_BITS; j++) begin
      m_a[j] = (grp_a == LBL_W'(j));
      m_b[j] = (grp_b == LBL_W'(j));
    end
  end

  assign same_node = (node_a == node_b);
  assign xm_a      = same_node ? m_a : '0;
  assign xm_b      = same_node ? m_b : '0;

  assign hit   = (|(row_a & m_b)) | (|(row_b & m_a));
  // one node on both edges: both rows are the same word
  assign new_a = (row_a & ~m_a & ~xm_b) | m_b | xm_a;
  assign new_b = (row_b & ~m_b & ~xm_a) | m_a | xm_b;

endmodule

FILE: src/bipartite_edge_swap_sampler_core.sv
// ----------------------------------------------------------------------------
// bipartite_edge_swap_sampler_core
// Edge table and adjacency bitmap in two single-port RAMs, driven by a
// sequencer that loads, reads, clears and swaps edges one request at a time.
// ----------------------------------------------------------------------------
// A swap is the longest sequence, set by the single ports of the edge RAM
// and adjacency RAM (two reads each, then two write-backs); a rejected
// swap writes nothing back. The result is registered from the response
// state once the output is free, and waits there while it is stalled.
// Reset clears control, edge_count and the per-row valid bits of the bitmap
// at once (no clearing pass); the edge table is undefined until loaded.
module bipartite_edge_swap_sampler_core #(
  parameter int MAX_EDGES  = 256,
  parameter int MAX_NODES  = 64,
  parameter int MAX_GROUPS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bes_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bes_pkg::FN_W-1:0]  in_func,
  input  logic [bes_pkg::IDX_W-1:0] in_index_a,
  input  logic [bes_pkg::IDX_W-1:0] in_index_b,
  input  logic [bes_pkg::LBL_W-1:0] in_node_in,
  input  logic [bes_pkg::LBL_W-1:0] in_group_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bes_pkg::ST_W-1:0]  out_status,
  output logic [bes_pkg::LBL_W-1:0] out_node_out,
  output logic [bes_pkg::LBL_W-1:0] out_group_out
);
  import bes_pkg::*;

  localparam int EDGE_DEPTH = (MAX_EDGES < (1 << IDX_W)) ? MAX_EDGES : (1 << IDX_W);
  localparam int NODE_DEPTH = (MAX_NODES < (1 << LBL_W)) ? MAX_NODES : (1 << LBL_W);
  localparam int GRP_BITS   = (MAX_GROUPS < (1 << LBL_W)) ? MAX_GROUPS : (1 << LBL_W);
  localparam int EA_W       = $clog2(EDGE_DEPTH);
  localparam int NA_W       = $clog2(NODE_DEPTH);
  localparam int EW         = 2 * LBL_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_WR,
    S_READ_CAP,
    S_SW_B,
    S_SW_RA,
    S_SW_RB,
    S_SW_DEC,
    S_SW_WB,
    S_RESP
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    edge_cnt_r;
  logic [NODE_DEPTH-1:0] row_vld_r;
  logic                rvld_q_r;

  logic [IDX_W-1:0]    ia_r;
  logic [IDX_W-1:0]    ib_r;
  logic [LBL_W-1:0]    nin_r;
  logic [LBL_W-1:0]    gin_r;
  logic [LBL_W-1:0]    n1_r;
  logic [LBL_W-1:0]    g1_r;
  logic [LBL_W-1:0]    n2_r;
  logic [LBL_W-1:0]    g2_r;
  logic [GRP_BITS-1:0] r1_r;
  logic [GRP_BITS-1:0] row2_r;

  status_t             st_r;
  logic [LBL_W-1:0]    res_node_r;
  logic [LBL_W-1:0]    res_grp_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [LBL_W-1:0]    out_node_r;
  logic [LBL_W-1:0]    out_grp_r;

  logic                in_acc;
  logic                ia_ok;
  logic                ib_ok;
  logic                lbl_ok;
  logic                out_free;

  logic                e_we;
  logic [EA_W-1:0]     e_addr;
  logic [EW-1:0]       e_wdata;
  logic [EW-1:0]       e_rdata;
  logic [LBL_W-1:0]    e_node;
  logic [LBL_W-1:0]    e_grp;

  logic                a_we;
  logic [NA_W-1:0]     a_addr;
  logic [GRP_BITS-1:0] a_wdata;
  logic [GRP_BITS-1:0] a_rdata;
  logic [GRP_BITS-1:0] a_row;

  logic [GRP_BITS-1:0] ld_mask;
  logic                sw_hit;
  logic [GRP_BITS-1:0] sw_new_a;
  logic [GRP_BITS-1:0] sw_new_b;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign ia_ok  = ({1'b0, in_index_a} < edge_cnt_r) && (32'(in_index_a) < MAX_EDGES);
  assign ib_ok  = ({1'b0, in_index_b} < edge_cnt_r) && (32'(in_index_b) < MAX_EDGES);
  assign lbl_ok = (32'(in_node_in) < MAX_NODES) && (32'(in_group_in) < MAX_GROUPS);

  assign e_node = e_rdata[EW-1:LBL_W];
  assign e_grp  = e_rdata[LBL_W-1:0];
  assign a_row  = a_rdata & {GRP_BITS{rvld_q_r}};

  always_comb begin
    for (int j = 0; j < GRP_BITS; j++) begin
      ld_mask[j] = (gin_r == LBL_W'(j));
    end
  end

  // memory port steering
  always_comb begin
    e_we    = 1'b0;
    e_addr  = ia_r[EA_W-1:0];
    e_wdata = {n1_r, g2_r};
    a_we    = 1'b0;
    a_addr  = n1_r[NA_W-1:0];
    a_wdata = sw_new_a;
    case (state_r)
      S_IDLE: begin
        e_addr  = in_index_a[EA_W-1:0];
        e_we    = in_acc && (in_func == FN_LOAD) && ia_ok && lbl_ok;
        e_wdata = {in_node_in, in_group_in};
        a_addr  = in_node_in[NA_W-1:0];
      end
      S_LOAD_WR: begin
        a_addr  = nin_r[NA_W-1:0];
        a_we    = 1'b1;
        a_wdata = a_row | ld_mask;
      end
      S_SW_B: begin
        e_addr = ib_r[EA_W-1:0];
      end
      S_SW_RB: begin
        a_addr = n2_r[NA_W-1:0];
      end
      S_SW_DEC: begin
        e_we = !sw_hit;
        a_we = !sw_hit;
      end
      S_SW_WB: begin
        e_addr  = ib_r[EA_W-1:0];
        e_we    = 1'b1;
        e_wdata = {n2_r, g1_r};
        a_addr  = n2_r[NA_W-1:0];
        a_we    = 1'b1;
        a_wdata = row2_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_cnt_r  <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rvld_q_r <= row_vld_r[a_addr];
      if (cfg_we) begin
        edge_cnt_r <= cfg_wdata;
      end
      if (a_we) begin
        row_vld_r[a_addr] <= 1'b1;
      end
      if ((state_r == S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ia_r       <= in_index_a;
            ib_r       <= in_index_b;
            nin_r      <= in_node_in;
            gin_r      <= in_group_in;
            res_node_r <= '0;
            res_grp_r  <= '0;
            case (in_func)
              FN_LOAD: begin
                if (ia_ok && lbl_ok) begin
                  st_r    <= ST_DONE;
                  state_r <= S_LOAD_WR;
                end else begin
                  st_r    <= ST_BAD;
                  state_r <= S_RESP;
                end
              end
              FN_SWAP: begin
                if (!ia_ok || !ib_ok) begin
                  st_r    <= ST_BAD;
                  state_r <= S_RESP;
                end else if (in_index_a == in_index_b) begin
                  st_r    <= ST_SAME;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_DONE;
                  state_r <= S_SW_B;
                end
              end
              FN_CLEAR: begin
                row_vld_r <= '0;
                st_r      <= ST_DONE;
                state_r   <= S_RESP;
              end
              FN_READ: begin
                if (ia_ok) begin
                  st_r    <= ST_DONE;
                  state_r <= S_READ_CAP;
                end else begin
                  st_r    <= ST_BAD;
                  state_r <= S_RESP;
                end
              end
              default: begin
                st_r    <= ST_BAD;
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_LOAD_WR: begin
          state_r <= S_RESP;
        end
        S_READ_CAP: begin
          res_node_r <= e_node;
          res_grp_r  <= e_grp;
          st_r       <= ST_READ;
          state_r    <= S_RESP;
        end
        S_SW_B: begin
          n1_r    <= e_node;
          g1_r    <= e_grp;
          state_r <= S_SW_RA;
        end
        S_SW_RA: begin
          n2_r    <= e_node;
          g2_r    <= e_grp;
          state_r <= S_SW_RB;
        end
        S_SW_RB: begin
          r1_r    <= a_row;
          state_r <= S_SW_DEC;
        end
        S_SW_DEC: begin
          row2_r <= sw_new_b;
          if (sw_hit) begin
            st_r    <= ST_REJECTED;
            state_r <= S_RESP;
          end else begin
            st_r    <= ST_SWAPPED;
            state_r <= S_SW_WB;
          end
        end
        S_SW_WB: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_status_r <= st_r;
            out_node_r   <= res_node_r;
            out_grp_r    <= res_grp_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  bes_ram #(
    .WIDTH (EW),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .addr  (e_addr),
    .wdata (e_wdata),
    .rdata (e_rdata)
  );

  bes_ram #(
    .WIDTH (GRP_BITS),
    .DEPTH (NODE_DEPTH)
  ) u_adj_ram (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (a_wdata),
    .rdata (a_rdata)
  );

  bes_row_upd #(
    .GRP_BITS (GRP_BITS)
  ) u_row_upd (
    .row_a  (r1_r),
    .row_b  (a_row),
    .node_a (n1_r),
    .node_b (n2_r),
    .grp_a  (g1_r),
    .grp_b  (g2_r),
    .hit    (sw_hit),
    .new_a  (sw_new_a),
    .new_b  (sw_new_b)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_node_out  = out_node_r;
  assign out_group_out = out_grp_r;

  a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FN_CLEAR)) |=> (row_vld_r == '0))
    else $error("bitmap rows still valid after clear");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside response state");

  a_edge_wr: assert property (@(posedge clk) disable iff (!rst_n)
    e_we |-> ((state_r == S_IDLE) || (state_r == S_SW_DEC) || (state_r == S_SW_WB)))
    else $error("edge RAM written in unexpected state");

  a_swap_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_WB) |-> ($past(state_r == S_SW_DEC) && (st_r == ST_SWAPPED)))
    else $error("second write-back without accepted swap");

endmodule

FILE: tb/bipartite_edge_swap_sampler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bipartite_edge_swap_sampler_core_tb
// Feeds load, swap, clear and read requests through the sampler with random
// gaps and stalls on both sides. Every reply is checked against a local edge
// table and adjacency bitmap that are kept in step with accepted requests.
// ----------------------------------------------------------------------------
module bipartite_edge_swap_sampler_core_tb;
  import bes_pkg::*;

  localparam int EDGE_SLOTS      = 256;
  localparam int NODE_ROWS       = 64;
  localparam int IDLE_PCT        = 9;
  localparam int HOLD_AT         = 700;
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [LBL_W-1:0]  node;
    logic [LBL_W-1:0]  group;
  } sampler_req_t;

  typedef struct packed {
    status_t           status;
    logic [LBL_W-1:0]  node;
    logic [LBL_W-1:0]  group;
  } sampler_reply_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic [FN_W-1:0]  in_func     = FN_LOAD;
  logic [IDX_W-1:0] in_index_a  = '0;
  logic [IDX_W-1:0] in_index_b  = '0;
  logic [LBL_W-1:0] in_node_in  = '0;
  logic [LBL_W-1:0] in_group_in = '0;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [LBL_W-1:0] out_node_out;
  logic [LBL_W-1:0] out_group_out;

  bipartite_edge_swap_sampler_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_index_a   (in_index_a),
    .in_index_b   (in_index_b),
    .in_node_in   (in_node_in),
    .in_group_in  (in_group_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_node_out (out_node_out),
    .out_group_out(out_group_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the edge table, bitmap and edge_count
  logic [LBL_W-1:0] node_tbl  [EDGE_SLOTS];
  logic [LBL_W-1:0] group_tbl [EDGE_SLOTS];
  logic [63:0]      adj_rows  [NODE_ROWS];
  logic [CNT_W-1:0] edges_in_use = '0;

  sampler_req_t   queued_requests [$];
  sampler_reply_t due_replies     [$];
  sampler_req_t   offered;

  bit calm      = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int replies_seen = 0;
  int quiet_cycles = 0;
  int status_tally [8];

  function automatic sampler_reply_t sampler_reply(sampler_req_t r);
    sampler_reply_t rep;
    logic [LBL_W-1:0] n1, g1, n2, g2;
    rep.status = ST_DONE;
    rep.node   = '0;
    rep.group  = '0;
    case (r.func)
      FN_LOAD: begin
        if (r.index_a >= edges_in_use) begin
          rep.status = ST_BAD;
        end else begin
          node_tbl[r.index_a]  = r.node;
          group_tbl[r.index_a] = r.group;
          adj_rows[r.node][r.group] = 1'b1;
        end
      end
      FN_SWAP: begin
        if (r.index_a >= edges_in_use || r.index_b >= edges_in_use) begin
          rep.status = ST_BAD;
        end else if (r.index_a == r.index_b) begin
          rep.status = ST_SAME;
        end else begin
          n1 = node_tbl[r.index_a];
          g1 = group_tbl[r.index_a];
          n2 = node_tbl[r.index_b];
          g2 = group_tbl[r.index_b];
          if (!adj_rows[n1][g2] && !adj_rows[n2][g1]) begin
            group_tbl[r.index_a] = g2;
            group_tbl[r.index_b] = g1;
            adj_rows[n1][g1] = 1'b0;
            adj_rows[n2][g2] = 1'b0;
            adj_rows[n1][g2] = 1'b1;
            adj_rows[n2][g1] = 1'b1;
            rep.status = ST_SWAPPED;
          end else begin
            rep.status = ST_REJECTED;
          end
        end
      end
      FN_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      default: begin
        if (r.index_a >= edges_in_use) begin
          rep.status = ST_BAD;
        end else begin
          rep.status = ST_READ;
          rep.node   = node_tbl[r.index_a];
          rep.group  = group_tbl[r.index_a];
        end
      end
    endcase
    return rep;
  endfunction

  // request driver
  always @(posedge clk) begin : feed
    sampler_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_replies.insert(due_replies.size(), sampler_reply(offered));
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = queued_requests.pop_front();
          offered     <= nxt;
          in_valid    <= 1'b1;
          in_func     <= nxt.func;
          in_index_a  <= nxt.index_a;
          in_index_b  <= nxt.index_b;
          in_node_in  <= nxt.node;
          in_group_in <= nxt.group;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string label, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // reply monitor and receiver stalls
  always @(posedge clk) begin : sink
    sampler_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none expected, status %0d node %0d group %0d",
                   $time, out_status, out_node_out, out_group_out);
        end else begin
          want = due_replies.pop_front();
          status_tally[want.status]++;
          check_field("status", 8'(want.status), 8'(out_status));
          check_field("node_out", 8'(want.node), 8'(out_node_out));
          check_field("group_out", 8'(want.group), 8'(out_group_out));
        end
      end
      if (!hold_used && replies_seen >= HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: timeout, no request or reply moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic post(func_t f, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                      logic [LBL_W-1:0] n, logic [LBL_W-1:0] g);
    sampler_req_t r;
    r = '{func: f, index_a: a, index_b: b, node: n, group: g};
    queued_requests.insert(queued_requests.size(), r);
  endtask

  function automatic logic [IDX_W-1:0] rnd_index();
    return IDX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [LBL_W-1:0] rnd_label();
    return LBL_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [LBL_W-1:0] rnd_span(int span);
    return LBL_W'($urandom_range(0, span));
  endfunction

  // mostly in range; otherwise any index, which may be out of range
  function automatic logic [IDX_W-1:0] pick_edge(int ec);
    if (ec > 0 && $urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, ec - 1));
    return rnd_index();
  endfunction

  task automatic settle();
    do @(posedge clk);
    while (queued_requests.size() != 0 || in_valid || due_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_edge_count(logic [CNT_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    edges_in_use = v;
  endtask

  task automatic run_phase(int ec, bit reload, int span, int ops);
    int roll;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    write_edge_count(ec[CNT_W-1:0]);
    if (reload) begin
      post(FN_CLEAR, rnd_index(), rnd_index(), rnd_label(), rnd_label());
      for (int i = 0; i < ec; i++) begin
        post(FN_LOAD, i[IDX_W-1:0], rnd_index(), rnd_span(span), rnd_span(span));
      end
    end
    for (int k = 0; k < ops; k++) begin
      roll = $urandom_range(0, 99);
      a = pick_edge(ec);
      b = ($urandom_range(0, 19) == 0) ? a : pick_edge(ec);
      if (roll < 70) begin
        post(FN_SWAP, a, b, rnd_label(), rnd_label());
      end else if (roll < 83) begin
        post(FN_READ, a, rnd_index(), rnd_label(), rnd_label());
      end else if (roll < 98) begin
        post(FN_LOAD, a, rnd_index(), rnd_span(span), rnd_span(span));
      end else begin
        post(FN_CLEAR, rnd_index(), rnd_index(), rnd_label(), rnd_label());
      end
    end
    settle();
  endtask

  initial begin
    foreach (node_tbl[i]) node_tbl[i] = '0;
    foreach (group_tbl[i]) group_tbl[i] = '0;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no edges in use: everything indexed is refused
    write_edge_count('0);
    post(FN_LOAD, 8'd0, rnd_index(), 6'd5, 6'd5);
    post(FN_READ, 8'd0, rnd_index(), rnd_label(), rnd_label());
    post(FN_SWAP, 8'd0, 8'd1, rnd_label(), rnd_label());
    post(FN_CLEAR, rnd_index(), rnd_index(), rnd_label(), rnd_label());

    write_edge_count(9'd4);
    post(FN_LOAD, 8'd0, rnd_index(), 6'd0, 6'd0);
    post(FN_LOAD, 8'd1, rnd_index(), 6'd63, 6'd63);
    post(FN_LOAD, 8'd2, rnd_index(), 6'd0, 6'd63);
    post(FN_LOAD, 8'd3, rnd_index(), 6'd63, 6'd0);
    post(FN_LOAD, 8'd255, 8'd255, 6'd63, 6'd63);
    post(FN_SWAP, 8'd0, 8'd1, rnd_label(), rnd_label());   // both new pairs exist
    post(FN_SWAP, 8'd2, 8'd2, rnd_label(), rnd_label());
    post(FN_SWAP, 8'd1, 8'd4, rnd_label(), rnd_label());
    post(FN_SWAP, 8'd4, 8'd4, rnd_label(), rnd_label());   // bad wins over same
    post(FN_SWAP, 8'd0, 8'd255, rnd_label(), rnd_label());
    post(FN_READ, 8'd3, rnd_index(), rnd_label(), rnd_label());
    post(FN_READ, 8'd255, rnd_index(), rnd_label(), rnd_label());
    post(FN_CLEAR, rnd_index(), rnd_index(), rnd_label(), rnd_label());
    post(FN_SWAP, 8'd0, 8'd1, rnd_label(), rnd_label());   // bitmap empty, goes through
    post(FN_READ, 8'd0, rnd_index(), rnd_label(), rnd_label());
    post(FN_READ, 8'd1, rnd_index(), rnd_label(), rnd_label());
    post(FN_LOAD, 8'd2, rnd_index(), 6'd21, 6'd42);        // old pair bit stays set
    post(FN_SWAP, 8'd2, 8'd3, rnd_label(), rnd_label());
    post(FN_SWAP, 8'd0, 8'd2, rnd_label(), rnd_label());
    post(FN_READ, 8'd2, rnd_index(), rnd_label(), rnd_label());

    run_phase(256, 1'b1, 63, 120);
    run_phase(1, 1'b1, 63, 15);
    run_phase(2, 1'b1, 1, 30);
    calm = 1'b1;
    run_phase(17, 1'b1, 3, 150);
    calm = 1'b0;
    run_phase(40, 1'b1, 7, 200);
    run_phase(200, 1'b0, 63, 60);
    run_phase(256, 1'b0, 63, 40);

    $display("Ran %0d requests over edge_count 0 to 256: %0d swaps made, %0d refused,",
             requests_taken, status_tally[ST_SWAPPED], status_tally[ST_REJECTED]);
    $display("%0d same-index, %0d bad-index, %0d loads/clears, %0d reads; %0d mismatches.",
             status_tally[ST_SAME], status_tally[ST_BAD], status_tally[ST_DONE],
             status_tally[ST_READ], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
